// ===== hw/rtl/mmq_pkg.sv =====
// ----------------------------------------------------------------------------
// mmq_pkg
// Shared sizes, codes and word layouts of the mailbox message queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package mmq_pkg;

	localparam int NUM_TASKS     = 8;
	localparam int NUM_BOXES     = 8;
	localparam int NUM_SLOTS     = 32;
	localparam int MESSAGE_WIDTH = 16;
	localparam int PAYLOAD_WIDTH = 32;

	localparam int ID_W   = 3;
	localparam int MASK_W = 8;
	localparam int OP_W   = 3;
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

	typedef enum logic [OP_W-1:0] {
		OP_INIT_BOX    = 3'd0,
		OP_SET_DEFAULT = 3'd1,
		OP_SEND_TASK   = 3'd2,
		OP_SEND_BOX    = 3'd3,
		OP_GET         = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_NODEF = 3'd1,
		ST_EMPTY = 3'd2,
		ST_FULL  = 3'd3,
		ST_BUSY  = 3'd4
	} status_t;

	// s_tdata layout, last member in the lowest bits
	typedef struct packed {
		logic [PAYLOAD_WIDTH-1:0] payload_word;
		logic [MESSAGE_WIDTH-1:0] message_word;
		logic [MASK_W-1:0]        trigger_mask;
		logic [ID_W-1:0]          dest_task;
		logic [ID_W-1:0]          box_index;
		logic [ID_W-1:0]          current_task;
	} in_data_t;

	localparam int IN_FIELDS_W = $bits(in_data_t);
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

	typedef struct packed {
		logic [OP_W-1:0] opcode;
		in_data_t        data;
	} req_t;

	// m_tdata layout, last member in the lowest bits
	typedef struct packed {
		logic [MASK_W-1:0]        trigger_bits;
		logic [ID_W-1:0]          trigger_task;
		logic [CNT_W-1:0]         out_count;
		logic [ID_W-1:0]          out_sender;
		logic [PAYLOAD_WIDTH-1:0] out_payload;
		logic [MESSAGE_WIDTH-1:0] out_message;
	} out_data_t;

	localparam int OUT_FIELDS_W = $bits(out_data_t);
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef struct packed {
		logic    trigger_valid;
		status_t status;
	} out_user_t;

	localparam int OUT_USER_W = $bits(out_user_t);

	typedef struct packed {
		out_user_t user;
		out_data_t data;
	} rsp_t;

	typedef struct packed {
		logic [MESSAGE_WIDTH-1:0] message;
		logic [PAYLOAD_WIDTH-1:0] payload;
		logic [ID_W-1:0]          sender;
	} slot_entry_t;

	typedef struct packed {
		logic              alloc;
		logic              release_en;
		logic [SLOT_W-1:0] release_slot;
		logic              link;
		logic [SLOT_W-1:0] link_slot;
		slot_entry_t       entry;
	} pool_cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] free_head;
		logic [CNT_W-1:0]  free_count;
		logic [SLOT_W-1:0] rd_next;
		slot_entry_t       rd_entry;
	} pool_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_mailbox_message_queue_core.sv =====
// ----------------------------------------------------------------------------
// multi_mailbox_message_queue_core
// Mailbox engine: per-box envelope queues over a shared slot pool.
// ----------------------------------------------------------------------------
// One request word in, one result word out. A request is registered, then
// executed combinationally against the mailbox tables and the slot pool; its
// result is held in an output register, so the core takes one request every
// cycle while m_tready keeps the output free, and m_tvalid rises once the
// request has passed through the request register and the output register.
// The output register lets a new request enter while a result waits; with
// both registers full, s_tready drops until m_tready frees the output.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_mailbox_message_queue_core
	import mmq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// current_task, box_index, dest_task, trigger_mask, message_word,
	// payload_word, zero pad
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  wire logic [OP_W-1:0]       s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// out_message, out_payload, out_sender, out_count, trigger_task,
	// trigger_bits, zero pad
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// status, trigger_valid
	output logic [OUT_USER_W-1:0]      m_tuser
);

	logic       s1_valid_q;
	req_t       req_s1;
	logic       out_valid_q;
	rsp_t       rsp_q;
	logic       advance;
	rsp_t       rsp;
	pool_cmd_t  pool_cmd;
	pool_stat_t pool_stat;
	logic [SLOT_W-1:0] rd_slot;

	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(rsp_q.data);
	assign m_tuser  = rsp_q.user;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.opcode <= s_tuser;
			req_s1.data   <= s_tdata[IN_FIELDS_W-1:0];
		end
		if (advance) begin
			rsp_q <= rsp;
		end
	end

	mmq_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.req     (req_s1),
		.stat    (pool_stat),
		.cmd     (pool_cmd),
		.rd_slot (rd_slot),
		.rsp     (rsp)
	);

	mmq_pool u_pool (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (pool_cmd),
		.rd_slot (rd_slot),
		.stat    (pool_stat)
	);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> s_tready)
		else $error("input stalled with empty request stage");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !advance)
		else $error("result register overwritten while stalled");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result word changed while stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/mmq_pool.sv =====
// ----------------------------------------------------------------------------
// mmq_pool
// Shared envelope slots: link array, envelope storage and the free list.
// ----------------------------------------------------------------------------
`default_nettype none

module mmq_pool
	import mmq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pool_cmd_t         cmd,
	input  wire logic [SLOT_W-1:0] rd_slot,
	output pool_stat_t             stat
);

	logic [SLOT_W-1:0] slot_next_q [NUM_SLOTS];
	slot_entry_t       slot_data_q [NUM_SLOTS];
	logic [SLOT_W-1:0] free_head_q;
	logic [CNT_W-1:0]  free_count_q;

	assign stat.free_head  = free_head_q;
	assign stat.free_count = free_count_q;
	assign stat.rd_next    = slot_next_q[rd_slot];
	assign stat.rd_entry   = slot_data_q[rd_slot];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_next_q[i] <= (i + 1 < NUM_SLOTS) ? SLOT_W'(i + 1) : '0;
			end
			free_head_q  <= '0;
			free_count_q <= CNT_W'(NUM_SLOTS);
		end else begin
			if (cmd.link) begin
				slot_next_q[cmd.link_slot] <= free_head_q;
			end
			if (cmd.release_en) begin
				slot_next_q[cmd.release_slot] <= free_head_q;
			end
			if (cmd.alloc) begin
				free_head_q  <= stat.rd_next;
				free_count_q <= free_count_q - 1'b1;
			end else if (cmd.release_en) begin
				free_head_q  <= cmd.release_slot;
				free_count_q <= free_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			slot_data_q[free_head_q] <= cmd.entry;
		end
	end

	a_alloc_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> free_count_q != '0)
		else $error("slot allocated from an empty free list");

	a_alloc_reads_head: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> rd_slot == free_head_q)
		else $error("allocation does not read the free list head link");

	a_release_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.release_en |=> free_head_q == $past(cmd.release_slot))
		else $error("released slot not on front of free list");

endmodule

`default_nettype wire

// ===== hw/rtl/mmq_engine.sv =====
// ----------------------------------------------------------------------------
// mmq_engine
// Mailbox and default tables, request decode and result formation.
// ----------------------------------------------------------------------------
`default_nettype none

module mmq_engine
	import mmq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire req_t              req,
	input  wire pool_stat_t        stat,
	output pool_cmd_t              cmd,
	output logic [SLOT_W-1:0]      rd_slot,
	output rsp_t                   rsp
);

	logic              def_valid_q [NUM_TASKS];
	logic [ID_W-1:0]   def_box_q   [NUM_TASKS];
	logic [ID_W-1:0]   owner_q     [NUM_BOXES];
	logic [MASK_W-1:0] trig_q      [NUM_BOXES];
	logic [SLOT_W-1:0] head_q      [NUM_BOXES];
	logic [SLOT_W-1:0] tail_q      [NUM_BOXES];
	logic [CNT_W-1:0]  count_q     [NUM_BOXES];

	op_t               op;
	logic [ID_W-1:0]   task_sel;
	logic              task_ok;
	logic              def_valid_sel;
	logic [ID_W-1:0]   box_sel;
	logic              box_ok;
	logic [CNT_W-1:0]  cnt;
	logic [CNT_W-1:0]  cnt_dec;
	logic [SLOT_W-1:0] head_sel;
	logic [SLOT_W-1:0] tail_sel;
	logic              init_we;
	logic              def_we;
	logic              dlv_we;
	logic              get_we;

	assign op            = op_t'(req.opcode);
	assign task_sel      = (op == OP_SEND_TASK) ? req.data.dest_task : req.data.current_task;
	assign task_ok       = 32'(task_sel) < NUM_TASKS;
	assign def_valid_sel = def_valid_q[task_sel];
	assign box_sel       = (op == OP_SEND_TASK) ? def_box_q[task_sel] : req.data.box_index;
	assign box_ok        = (32'(box_sel) < NUM_BOXES) &&
	                       ((op != OP_SEND_TASK) || (task_ok && def_valid_sel));
	assign cnt           = count_q[box_sel];
	assign cnt_dec       = cnt - 1'b1;
	assign head_sel      = head_q[box_sel];
	assign tail_sel      = tail_q[box_sel];
	assign rd_slot       = (op == OP_GET) ? head_sel : stat.free_head;

	always_comb begin
		rsp     = '0;
		init_we = 1'b0;
		def_we  = 1'b0;
		dlv_we  = 1'b0;
		get_we  = 1'b0;
		case (op)
			OP_INIT_BOX: begin
				if (!box_ok) begin
					rsp.user.status = ST_NODEF;
				end else if (cnt != '0) begin
					rsp.user.status    = ST_BUSY;
					rsp.data.out_count = cnt;
				end else begin
					init_we = 1'b1;
					def_we  = task_ok && !def_valid_sel;
				end
			end
			OP_SET_DEFAULT: begin
				if (!box_ok || !task_ok) begin
					rsp.user.status    = ST_NODEF;
					rsp.data.out_count = box_ok ? cnt : '0;
				end else begin
					def_we             = 1'b1;
					rsp.data.out_count = cnt;
				end
			end
			OP_SEND_TASK, OP_SEND_BOX: begin
				if (!box_ok) begin
					rsp.user.status = ST_NODEF;
				end else if (stat.free_count == '0) begin
					rsp.user.status    = ST_FULL;
					rsp.data.out_count = cnt;
				end else begin
					dlv_we                  = 1'b1;
					rsp.data.out_count      = cnt + 1'b1;
					rsp.user.trigger_valid  = 1'b1;
					rsp.data.trigger_task   = owner_q[box_sel];
					rsp.data.trigger_bits   = trig_q[box_sel];
				end
			end
			OP_GET: begin
				if (!box_ok || cnt == '0) begin
					rsp.user.status = ST_EMPTY;
				end else begin
					get_we                 = 1'b1;
					rsp.data.out_message   = stat.rd_entry.message;
					rsp.data.out_payload   = stat.rd_entry.payload;
					rsp.data.out_sender    = stat.rd_entry.sender;
					rsp.data.out_count     = cnt_dec;
					if (cnt_dec != '0) begin
						rsp.user.trigger_valid = 1'b1;
						rsp.data.trigger_task  = owner_q[box_sel];
						rsp.data.trigger_bits  = trig_q[box_sel];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cmd               = '0;
		cmd.alloc         = fire && dlv_we;
		cmd.link          = fire && dlv_we && (cnt != '0);
		cmd.link_slot     = tail_sel;
		cmd.release_en    = fire && get_we;
		cmd.release_slot  = head_sel;
		cmd.entry.message = req.data.message_word;
		cmd.entry.payload = req.data.payload_word;
		cmd.entry.sender  = req.data.current_task;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				def_valid_q[i] <= 1'b0;
				def_box_q[i]   <= '0;
			end
			for (int i = 0; i < NUM_BOXES; i++) begin
				owner_q[i] <= '0;
				trig_q[i]  <= '0;
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (fire) begin
			if (def_we) begin
				def_valid_q[task_sel] <= 1'b1;
				def_box_q[task_sel]   <= req.data.box_index;
			end
			if (init_we) begin
				owner_q[box_sel] <= req.data.current_task;
				trig_q[box_sel]  <= req.data.trigger_mask;
				head_q[box_sel]  <= '0;
				tail_q[box_sel]  <= '0;
				count_q[box_sel] <= '0;
			end
			if (dlv_we) begin
				if (cnt == '0) begin
					head_q[box_sel] <= stat.free_head;
				end
				tail_q[box_sel]  <= stat.free_head;
				count_q[box_sel] <= cnt + 1'b1;
			end
			if (get_we) begin
				count_q[box_sel] <= cnt_dec;
				if (cnt_dec == '0) begin
					head_q[box_sel] <= '0;
					tail_q[box_sel] <= '0;
				end else begin
					head_q[box_sel] <= stat.rd_next;
				end
			end
		end
	end

endmodule

`default_nettype wire
